[rtl/ssb_pkg.sv]
// Package for the scaled sprite blitter: field widths, codes, words and control structs.
package ssb_pkg;

  localparam int SPR_DEPTH     = 4096;
  localparam int SPR_AW        = 12;
  localparam int CODE_W        = 8;
  localparam int COLOUR_W      = 16;
  localparam int FRAME_W       = 7;
  localparam int SCALE_W       = 12;
  localparam int POS_W         = 12;
  localparam int DIM_W         = 11;
  localparam int SRC_W         = 8;
  localparam int ORG_W         = 13;
  localparam int PIX_W         = 14;
  localparam int FB_W          = 17;
  localparam int Q_SHIFT       = 8;
  localparam int SCALE_FLOOR   = 16;
  localparam int DIV_STEPS     = 7;
  localparam int DIV_CNT_W     = 3;

  localparam int DEF_SPRITE_MAX_W = 64;
  localparam int DEF_SPRITE_MAX_H = 64;
  localparam int DEF_PAL_SIZE     = 16;
  localparam int DEF_SCREEN_W     = 320;
  localparam int DEF_SCREEN_H     = 240;

  typedef enum logic [1:0] {
    REQ_LOAD_PIXEL = 2'd0,
    REQ_LOAD_PAL   = 2'd1,
    REQ_DRAW       = 2'd2,
    REQ_STEP       = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ANCHOR_TOP_LEFT = 2'd0,
    ANCHOR_CENTRE   = 2'd1,
    ANCHOR_GROUND   = 2'd2
  } anchor_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ORG,
    ST_DIV,
    ST_ADDR,
    ST_SPR,
    ST_PAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [SPR_AW-1:0]         store_addr;
    logic [CODE_W-1:0]         pixel_code;
    logic [3:0]                palette_slot;
    logic [COLOUR_W-1:0]       palette_colour;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic [FRAME_W-1:0]        frame_width;
    logic [FRAME_W-1:0]        frame_height;
    logic [SCALE_W-1:0]        scale_fx;
    logic [1:0]                anchor_mode;
  } in_word_t;

  typedef struct packed {
    logic                write_enable;
    logic [FB_W-1:0]     fb_addr;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                draw_done;
  } out_word_t;

  typedef struct packed {
    logic load_pixel;
    logic load_pal;
    logic latch_draw;
    logic calc_dims;
    logic init_div;
    logic div_step;
    logic step_addr;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic drawing;
    logic dim_zero;
    logic div_last;
    logic out_free;
  } ctl_sts_t;

endpackage

[rtl/ssb_if.sv]
// Valid/ready channel interfaces for input and result words.
interface ssb_in_if;
  logic              valid;
  logic              ready;
  ssb_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssb_out_if;
  logic               valid;
  logic               ready;
  ssb_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/ssb_ctrl.sv]
// Controller state machine sequencing loads, draw set-up and pixel steps.
module ssb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_req,
  output logic              in_ready,
  input  ssb_pkg::ctl_sts_t sts,
  output ssb_pkg::ctl_cmd_t cmd
);

  ssb_pkg::state_t state_r, state_nxt;
  logic            acc;

  assign in_ready = (state_r == ssb_pkg::ST_IDLE);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ssb_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssb_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_req == ssb_pkg::REQ_DRAW) state_nxt = ssb_pkg::ST_MUL;
          else if (in_req == ssb_pkg::REQ_STEP && sts.drawing) state_nxt = ssb_pkg::ST_ADDR;
        end
      end
      ssb_pkg::ST_MUL: state_nxt = ssb_pkg::ST_ORG;
      ssb_pkg::ST_ORG: state_nxt = sts.dim_zero ? ssb_pkg::ST_IDLE : ssb_pkg::ST_DIV;
      ssb_pkg::ST_DIV: if (sts.div_last) state_nxt = ssb_pkg::ST_IDLE;
      ssb_pkg::ST_ADDR: state_nxt = ssb_pkg::ST_SPR;
      ssb_pkg::ST_SPR: state_nxt = ssb_pkg::ST_PAL;
      ssb_pkg::ST_PAL: state_nxt = ssb_pkg::ST_OUT;
      ssb_pkg::ST_OUT: if (sts.out_free) state_nxt = ssb_pkg::ST_IDLE;
      default: state_nxt = ssb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ssb_pkg::ST_IDLE: begin
        cmd.load_pixel = acc && (in_req == ssb_pkg::REQ_LOAD_PIXEL);
        cmd.load_pal   = acc && (in_req == ssb_pkg::REQ_LOAD_PAL);
        cmd.latch_draw = acc && (in_req == ssb_pkg::REQ_DRAW);
      end
      ssb_pkg::ST_MUL:  cmd.calc_dims = 1'b1;
      ssb_pkg::ST_ORG:  cmd.init_div  = !sts.dim_zero;
      ssb_pkg::ST_DIV:  cmd.div_step  = 1'b1;
      ssb_pkg::ST_ADDR: cmd.step_addr = 1'b1;
      ssb_pkg::ST_SPR, ssb_pkg::ST_PAL: cmd = '0;
      ssb_pkg::ST_OUT:  cmd.load_out  = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/ssb_dpath.sv]
// Datapath: sprite and palette memories, draw geometry, step divider and pixel walk.
module ssb_dpath #(
  parameter int SPRITE_MAX_W = ssb_pkg::DEF_SPRITE_MAX_W,
  parameter int SPRITE_MAX_H = ssb_pkg::DEF_SPRITE_MAX_H,
  parameter int PAL_SIZE     = ssb_pkg::DEF_PAL_SIZE,
  parameter int SCREEN_W     = ssb_pkg::DEF_SCREEN_W,
  parameter int SCREEN_H     = ssb_pkg::DEF_SCREEN_H
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ssb_pkg::in_word_t  in_data,
  input  ssb_pkg::ctl_cmd_t  cmd,
  output ssb_pkg::ctl_sts_t  sts,
  output logic               out_valid,
  input  logic               out_ready,
  output ssb_pkg::out_word_t out_data
);

  localparam int PAL_AW = (PAL_SIZE > 1) ? $clog2(PAL_SIZE) : 1;
  localparam int FBP_W  = 2 * ssb_pkg::DIM_W + 1;

  // Memories.
  logic [ssb_pkg::CODE_W-1:0]   spr_mem [ssb_pkg::SPR_DEPTH];
  logic [ssb_pkg::COLOUR_W-1:0] pal_mem [PAL_SIZE];
  logic [ssb_pkg::CODE_W-1:0]   code_r;
  logic [ssb_pkg::COLOUR_W-1:0] pal_r;
  logic [8:0]                   slot_ext, code_ext;
  logic [PAL_AW-1:0]            pal_idx;

  // Latched draw request.
  logic [ssb_pkg::FRAME_W-1:0]       fw_r, fh_r, fw_cl, fh_cl;
  logic [ssb_pkg::SCALE_W-1:0]       s_r, s_fl;
  logic signed [ssb_pkg::POS_W-1:0]  x_r, y_r;
  logic [1:0]                        mode_r;
  logic [ssb_pkg::DIM_W-1:0]         dw_r, dh_r;
  logic [ssb_pkg::FRAME_W+ssb_pkg::SCALE_W-1:0] pw, ph;

  // Geometry and walk state.
  logic signed [ssb_pkg::ORG_W-1:0]  org_x_r, org_y_r;
  logic [ssb_pkg::DIM_W-1:0]         col_r, row_r, cerr_r, rerr_r;
  logic [ssb_pkg::SRC_W-1:0]         scol_r, srow_r;
  logic [ssb_pkg::FRAME_W-1:0]       wx_r, wy_r;
  logic [ssb_pkg::DIM_W-1:0]         rx_r, ry_r;
  logic                              drawing_r;

  // Divider.
  logic [ssb_pkg::FRAME_W-1:0]       dvx_r, dvy_r;
  logic [ssb_pkg::DIV_CNT_W-1:0]     dcnt_r;
  logic [ssb_pkg::DIM_W:0]           tx, ty;

  // Step pipeline.
  logic [ssb_pkg::SPR_AW-1:0]        sa_r;
  logic [ssb_pkg::DIM_W-1:0]         px_r, py_r;
  logic                              on_r, done_r;
  logic [ssb_pkg::FB_W-1:0]          fb_r;
  logic [FBP_W-1:0]                  fb_full;
  logic signed [ssb_pkg::PIX_W-1:0]  px, py;
  logic                              on_scr;
  logic [15:0]                       sa_full;

  // Walk next values.
  logic [ssb_pkg::DIM_W-1:0]         col_nxt, row_nxt, cerr_nxt, rerr_nxt;
  logic [ssb_pkg::SRC_W-1:0]         scol_nxt, srow_nxt;
  logic [ssb_pkg::DIM_W:0]           ce_sum, re_sum;
  logic                              done_nxt;

  logic                              out_valid_r;
  ssb_pkg::out_word_t                out_r;

  // Stores.
  assign slot_ext = {5'd0, in_data.palette_slot};
  always_ff @(posedge clk) begin
    if (cmd.load_pixel) spr_mem[in_data.store_addr] <= in_data.pixel_code;
    if (cmd.load_pal && slot_ext < 9'(PAL_SIZE))
      pal_mem[slot_ext[PAL_AW-1:0]] <= in_data.palette_colour;
    code_r <= spr_mem[sa_r];
    pal_r  <= pal_mem[pal_idx];
  end

  assign code_ext = {1'b0, code_r};
  always_comb begin
    if (code_ext >= 9'(PAL_SIZE)) pal_idx = PAL_AW'(PAL_SIZE - 1);
    else                          pal_idx = code_ext[PAL_AW-1:0];
  end

  // Draw set-up.
  always_comb begin
    fw_cl = in_data.frame_width;
    fh_cl = in_data.frame_height;
    if ({2'd0, in_data.frame_width} > 9'(SPRITE_MAX_W)) fw_cl = ssb_pkg::FRAME_W'(SPRITE_MAX_W);
    if ({2'd0, in_data.frame_height} > 9'(SPRITE_MAX_H)) fh_cl = ssb_pkg::FRAME_W'(SPRITE_MAX_H);
    s_fl = (in_data.scale_fx < ssb_pkg::SCALE_W'(ssb_pkg::SCALE_FLOOR)) ?
           ssb_pkg::SCALE_W'(ssb_pkg::SCALE_FLOOR) : in_data.scale_fx;
  end

  assign pw = fw_r * s_r;
  assign ph = fh_r * s_r;

  assign tx = {rx_r, dvx_r[ssb_pkg::FRAME_W-1]};
  assign ty = {ry_r, dvy_r[ssb_pkg::FRAME_W-1]};

  // Pixel walk.
  assign px = ssb_pkg::PIX_W'(org_x_r) + ssb_pkg::PIX_W'({1'b0, col_r});
  assign py = ssb_pkg::PIX_W'(org_y_r) + ssb_pkg::PIX_W'({1'b0, row_r});
  assign on_scr = (px >= 0) && (px < ssb_pkg::PIX_W'(SCREEN_W)) &&
                  (py >= 0) && (py < ssb_pkg::PIX_W'(SCREEN_H));
  assign sa_full = 16'(srow_r) * 16'(fw_r) + 16'(scol_r);
  assign fb_full = FBP_W'(py_r) * FBP_W'(SCREEN_W) + FBP_W'(px_r);

  always_comb begin
    col_nxt  = col_r + 1'b1;
    scol_nxt = scol_r + ssb_pkg::SRC_W'(wx_r);
    ce_sum   = {1'b0, cerr_r} + {1'b0, rx_r};
    cerr_nxt = ce_sum[ssb_pkg::DIM_W-1:0];
    if (ce_sum >= {1'b0, dw_r}) begin
      cerr_nxt = ssb_pkg::DIM_W'(ce_sum - {1'b0, dw_r});
      scol_nxt = scol_nxt + 1'b1;
    end
    row_nxt  = row_r;
    srow_nxt = srow_r;
    rerr_nxt = rerr_r;
    re_sum   = '0;
    done_nxt = 1'b0;
    if (col_nxt >= dw_r) begin
      col_nxt  = '0;
      scol_nxt = '0;
      cerr_nxt = '0;
      row_nxt  = row_r + 1'b1;
      srow_nxt = srow_r + ssb_pkg::SRC_W'(wy_r);
      re_sum   = {1'b0, rerr_r} + {1'b0, ry_r};
      rerr_nxt = re_sum[ssb_pkg::DIM_W-1:0];
      if (re_sum >= {1'b0, dh_r}) begin
        rerr_nxt = ssb_pkg::DIM_W'(re_sum - {1'b0, dh_r});
        srow_nxt = srow_nxt + 1'b1;
      end
      if (row_nxt >= dh_r) begin
        row_nxt  = '0;
        srow_nxt = '0;
        rerr_nxt = '0;
        done_nxt = 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_draw) begin
      fw_r   <= fw_cl;
      fh_r   <= fh_cl;
      s_r    <= s_fl;
      x_r    <= in_data.pos_x;
      y_r    <= in_data.pos_y;
      mode_r <= in_data.anchor_mode;
    end
    if (cmd.calc_dims) begin
      dw_r <= pw[ssb_pkg::Q_SHIFT +: ssb_pkg::DIM_W];
      dh_r <= ph[ssb_pkg::Q_SHIFT +: ssb_pkg::DIM_W];
    end
    if (cmd.init_div) begin
      case (mode_r)
        ssb_pkg::ANCHOR_CENTRE: begin
          org_x_r <= ssb_pkg::ORG_W'(x_r) - ssb_pkg::ORG_W'({1'b0, dw_r >> 1});
          org_y_r <= ssb_pkg::ORG_W'(y_r) - ssb_pkg::ORG_W'({1'b0, dh_r >> 1});
        end
        ssb_pkg::ANCHOR_GROUND: begin
          org_x_r <= ssb_pkg::ORG_W'(x_r) - ssb_pkg::ORG_W'({1'b0, dw_r >> 1});
          org_y_r <= ssb_pkg::ORG_W'(y_r) - ssb_pkg::ORG_W'({1'b0, dh_r});
        end
        default: begin
          org_x_r <= ssb_pkg::ORG_W'(x_r);
          org_y_r <= ssb_pkg::ORG_W'(y_r);
        end
      endcase
      dvx_r <= fw_r;
      dvy_r <= fh_r;
    end else if (cmd.div_step) begin
      dvx_r <= dvx_r << 1;
      dvy_r <= dvy_r << 1;
    end
    if (cmd.step_addr) begin
      sa_r   <= sa_full[ssb_pkg::SPR_AW-1:0];
      px_r   <= px[ssb_pkg::DIM_W-1:0];
      py_r   <= py[ssb_pkg::DIM_W-1:0];
      on_r   <= on_scr;
      done_r <= done_nxt;
    end
    fb_r <= fb_full[ssb_pkg::FB_W-1:0];
  end

  // Control and walk state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drawing_r   <= 1'b0;
      out_valid_r <= 1'b0;
      dcnt_r      <= '0;
      col_r <= '0; row_r <= '0; cerr_r <= '0; rerr_r <= '0;
      scol_r <= '0; srow_r <= '0;
      wx_r <= '0; wy_r <= '0; rx_r <= '0; ry_r <= '0;
    end else begin
      if (cmd.latch_draw) drawing_r <= 1'b0;
      if (cmd.init_div) begin
        col_r <= '0; row_r <= '0; cerr_r <= '0; rerr_r <= '0;
        scol_r <= '0; srow_r <= '0;
        wx_r <= '0; wy_r <= '0; rx_r <= '0; ry_r <= '0;
        dcnt_r <= ssb_pkg::DIV_CNT_W'(ssb_pkg::DIV_STEPS - 1);
      end
      if (cmd.div_step) begin
        // Restoring division, one quotient bit per cycle for each axis.
        if (tx >= {1'b0, dw_r}) begin
          rx_r <= ssb_pkg::DIM_W'(tx - {1'b0, dw_r});
          wx_r <= {wx_r[ssb_pkg::FRAME_W-2:0], 1'b1};
        end else begin
          rx_r <= tx[ssb_pkg::DIM_W-1:0];
          wx_r <= {wx_r[ssb_pkg::FRAME_W-2:0], 1'b0};
        end
        if (ty >= {1'b0, dh_r}) begin
          ry_r <= ssb_pkg::DIM_W'(ty - {1'b0, dh_r});
          wy_r <= {wy_r[ssb_pkg::FRAME_W-2:0], 1'b1};
        end else begin
          ry_r <= ty[ssb_pkg::DIM_W-1:0];
          wy_r <= {wy_r[ssb_pkg::FRAME_W-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == '0) drawing_r <= 1'b1;
      end
      if (cmd.step_addr) begin
        col_r <= col_nxt; row_r <= row_nxt;
        cerr_r <= cerr_nxt; rerr_r <= rerr_nxt;
        scol_r <= scol_nxt; srow_r <= srow_nxt;
        if (done_nxt) drawing_r <= 1'b0;
      end
      if (cmd.load_out)             out_valid_r <= 1'b1;
      else if (out_ready)           out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.write_enable <= on_r && (code_r != '0);
      out_r.fb_addr      <= (on_r && (code_r != '0)) ? fb_r : '0;
      out_r.pixel_colour <= (on_r && (code_r != '0)) ? pal_r : '0;
      out_r.draw_done    <= done_r;
    end
  end

  assign sts.drawing  = drawing_r;
  assign sts.dim_zero = (dw_r == '0) || (dh_r == '0);
  assign sts.div_last = (dcnt_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/scaled_sprite_blit_core.sv]
// Top level of the scaled sprite blitter: controller and datapath joined to the channels.
//
//   Channel  Direction  Handshake     Word
//   in_ch    sink       valid/ready   in_word_t: load, palette, draw or step request
//   out_ch   source     valid/ready   out_word_t: one framebuffer write per step
//
// Loads are taken while idle. A draw word is latched, then come the two size multiplies,
// the origin and the restoring divider that yields the whole and remainder source
// steps; a zero size ends the draw at the origin. A step word passes through address,
// sprite memory read, palette memory read and the output register.
// Reset is synchronous and active low; it leaves the block idle with no draw open.
// The output register holds a word until it is taken; a step only waits if that
// register is still full when its own result is ready.
module scaled_sprite_blit_core #(
  parameter int SPRITE_MAX_W = ssb_pkg::DEF_SPRITE_MAX_W,
  parameter int SPRITE_MAX_H = ssb_pkg::DEF_SPRITE_MAX_H,
  parameter int PAL_SIZE     = ssb_pkg::DEF_PAL_SIZE,
  parameter int SCREEN_W     = ssb_pkg::DEF_SCREEN_W,
  parameter int SCREEN_H     = ssb_pkg::DEF_SCREEN_H
) (
  input logic       clk,
  input logic       rst_n,
  ssb_in_if.sink    in_ch,
  ssb_out_if.source out_ch
);

  ssb_pkg::ctl_cmd_t cmd;
  ssb_pkg::ctl_sts_t sts;

  // The controller decodes each accepted word and sequences the datapath.
  ssb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_req   (in_ch.data.req_type),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the stores, the geometry and the output register.
  ssb_dpath #(
    .SPRITE_MAX_W (SPRITE_MAX_W),
    .SPRITE_MAX_H (SPRITE_MAX_H),
    .PAL_SIZE     (PAL_SIZE),
    .SCREEN_W     (SCREEN_W),
    .SCREEN_H     (SCREEN_H)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

[tb/tb_scaled_sprite_blit_core.sv]
// Testbench for the scaled sprite blitter: directed and random words checked against a predictor.
module tb_scaled_sprite_blit_core;

  localparam int SCR_W = 320;
  localparam int SCR_H = 240;
  localparam int PAL_N = 16;
  localparam int MAX_FW = 64;
  localparam int MAX_FH = 64;

  logic clk;
  logic rst_n;

  ssb_in_if  in_ch ();
  ssb_out_if out_ch ();

  scaled_sprite_blit_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Words waiting for the driver, and framebuffer writes predicted but not yet seen.
  ssb_pkg::in_word_t  pending_words[$];
  ssb_pkg::out_word_t expected_writes[$];
  int        error_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_cycles;
  bit        hold_request;
  bit        hold_taken;

  // The predictor's own copy of the blitter state.
  logic [7:0]  spr_mem[4096];
  logic [15:0] pal_mem[16];
  int          org_x, org_y;
  int          dst_w, dst_h, dst_c, dst_r;
  int          s_col, c_err, s_row, r_err;
  int          sx_whole, sx_rem, sy_whole, sy_rem;
  int          fw_latched;
  bit          busy_drawing;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Applies one accepted word to the predictor; step words while drawing yield one write.
  task automatic predict_word(input ssb_pkg::in_word_t w);
    int fw, fh, s, dw, dh, x, y, px, py, code;
    ssb_pkg::out_word_t r;
    case (ssb_pkg::req_t'(w.req_type))
      ssb_pkg::REQ_LOAD_PIXEL: begin
        spr_mem[w.store_addr] = w.pixel_code;
      end
      ssb_pkg::REQ_LOAD_PAL: begin
        pal_mem[w.palette_slot] = w.palette_colour;
      end
      ssb_pkg::REQ_DRAW: begin
        fw = (w.frame_width > MAX_FW) ? MAX_FW : int'(w.frame_width);
        fh = (w.frame_height > MAX_FH) ? MAX_FH : int'(w.frame_height);
        s = (w.scale_fx < ssb_pkg::SCALE_FLOOR) ? ssb_pkg::SCALE_FLOOR : int'(w.scale_fx);
        dw = (fw * s) >> ssb_pkg::Q_SHIFT;
        dh = (fh * s) >> ssb_pkg::Q_SHIFT;
        busy_drawing = 1'b0;
        if (dw != 0 && dh != 0) begin
          x = int'(w.pos_x);
          y = int'(w.pos_y);
          if (w.anchor_mode == ssb_pkg::ANCHOR_CENTRE) begin
            x -= dw / 2;
            y -= dh / 2;
          end else if (w.anchor_mode == ssb_pkg::ANCHOR_GROUND) begin
            x -= dw / 2;
            y -= dh;
          end
          org_x = x; org_y = y;
          dst_w = dw; dst_h = dh;
          fw_latched = fw;
          sx_whole = fw / dw; sx_rem = fw % dw;
          sy_whole = fh / dh; sy_rem = fh % dh;
          dst_c = 0; dst_r = 0; s_col = 0; c_err = 0; s_row = 0; r_err = 0;
          busy_drawing = 1'b1;
        end
      end
      default: begin
        if (busy_drawing) begin
          r = '0;
          px = org_x + dst_c;
          py = org_y + dst_r;
          if (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H) begin
            code = int'(spr_mem[(s_row * fw_latched + s_col) & 12'hFFF]);
            if (code != 0) begin
              if (code >= PAL_N) code = PAL_N - 1;
              r.write_enable = 1'b1;
              r.fb_addr = ssb_pkg::FB_W'(py * SCR_W + px);
              r.pixel_colour = pal_mem[code];
            end
          end
          dst_c++;
          s_col += sx_whole;
          c_err += sx_rem;
          if (c_err >= dst_w) begin
            c_err -= dst_w;
            s_col++;
          end
          if (dst_c >= dst_w) begin
            dst_c = 0; s_col = 0; c_err = 0;
            dst_r++;
            s_row += sy_whole;
            r_err += sy_rem;
            if (r_err >= dst_h) begin
              r_err -= dst_h;
              s_row++;
            end
            if (dst_r >= dst_h) begin
              dst_r = 0; s_row = 0; r_err = 0;
              busy_drawing = 1'b0;
              r.draw_done = 1'b1;
            end
          end
          expected_writes.push_back(r);
        end
      end
    endcase
  endtask

  // Word builders. Only the fields that matter get chosen; the rest are random noise.
  function automatic ssb_pkg::in_word_t noise_word();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(ssb_pkg::in_word_t)-1:0];
  endfunction

  task automatic queue_pixel(input int addr, input int code);
    ssb_pkg::in_word_t w;
    w = noise_word();
    w.req_type = ssb_pkg::REQ_LOAD_PIXEL;
    w.store_addr = ssb_pkg::SPR_AW'(addr);
    w.pixel_code = ssb_pkg::CODE_W'(code);
    pending_words.push_back(w);
  endtask

  task automatic queue_palette(input int slot, input int colour);
    ssb_pkg::in_word_t w;
    w = noise_word();
    w.req_type = ssb_pkg::REQ_LOAD_PAL;
    w.palette_slot = 4'(slot);
    w.palette_colour = ssb_pkg::COLOUR_W'(colour);
    pending_words.push_back(w);
  endtask

  task automatic queue_draw(input int x, input int y, input int fw, input int fh,
                            input int s, input int mode);
    ssb_pkg::in_word_t w;
    w = noise_word();
    w.req_type = ssb_pkg::REQ_DRAW;
    w.pos_x = ssb_pkg::POS_W'(x);
    w.pos_y = ssb_pkg::POS_W'(y);
    w.frame_width = ssb_pkg::FRAME_W'(fw);
    w.frame_height = ssb_pkg::FRAME_W'(fh);
    w.scale_fx = ssb_pkg::SCALE_W'(s);
    w.anchor_mode = 2'(mode);
    pending_words.push_back(w);
  endtask

  task automatic queue_steps(input int n);
    ssb_pkg::in_word_t w;
    for (int i = 0; i < n; i++) begin
      w = noise_word();
      w.req_type = ssb_pkg::REQ_STEP;
      pending_words.push_back(w);
    end
  endtask

  // Fills a whole frame of the sprite store so any sampled pixel is known.
  task automatic queue_frame(input int fw, input int fh);
    int n;
    n = ((fw > MAX_FW) ? MAX_FW : fw) * ((fh > MAX_FH) ? MAX_FH : fh);
    for (int a = 0; a < n; a++) begin
      case ($urandom_range(0, 5))
        0: queue_pixel(a, 0);
        1: queue_pixel(a, $urandom_range(16, 255));
        default: queue_pixel(a, $urandom_range(1, 15));
      endcase
    end
  endtask

  // Waits until the driver has emptied the queue and every write has come back.
  task automatic drain();
    while (pending_words.size() != 0 || in_ch.valid || expected_writes.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Driver: offers the head of the queue, idling at the chosen rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_word(in_ch.data);
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.data <= pending_words.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted framebuffer write with the oldest prediction.
  always @(posedge clk) begin
    ssb_pkg::out_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("unexpected word fb_addr", int'(out_ch.data.fb_addr), 0);
        end else begin
          want = expected_writes.pop_front();
          if (out_ch.data.write_enable !== want.write_enable)
            report_mismatch("write_enable", int'(out_ch.data.write_enable),
                            int'(want.write_enable));
          if (out_ch.data.fb_addr !== want.fb_addr)
            report_mismatch("fb_addr", int'(out_ch.data.fb_addr), int'(want.fb_addr));
          if (out_ch.data.pixel_colour !== want.pixel_colour)
            report_mismatch("pixel_colour", int'(out_ch.data.pixel_colour),
                            int'(want.pixel_colour));
          if (out_ch.data.draw_done !== want.draw_done)
            report_mismatch("draw_done", int'(out_ch.data.draw_done), int'(want.draw_done));
        end
      end
      out_ch.ready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted here, so the pipeline fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      hold_taken <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_cycles <= 300;
      hold_taken <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  initial begin
    #40_000_000;
    $display("tb_scaled_sprite_blit_core: done, errors");
    $finish;
  end

  initial begin
    int fw, fh;
    clk = 1'b0;
    rst_n = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 66;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: every palette entry (colour extremes), an ignored-looking
    // high code, a small frame, each anchor mode, floor scale, zero size and restart.
    for (int i = 0; i < PAL_N; i++)
      queue_palette(i, (i == 0) ? 16'h0000 : (i == 15) ? 16'hFFFF : $urandom_range(0, 65535));
    queue_pixel(0, 8'hFF);
    queue_pixel(1, 0);
    queue_pixel(2, 3);
    queue_pixel(3, 15);
    queue_draw(0, 0, 2, 2, 256, ssb_pkg::ANCHOR_TOP_LEFT);
    queue_steps(5);                                // last one is an idle step
    queue_draw(319, 239, 2, 2, 512, ssb_pkg::ANCHOR_CENTRE);
    queue_steps(16);
    queue_draw(-2048, 2047, 2, 2, 0, ssb_pkg::ANCHOR_GROUND); // scale floored, size zero
    queue_steps(1);
    queue_draw(2047, -2048, 2, 2, 4095, 3);          // unknown anchor, off screen
    queue_steps(3);
    queue_draw(160, 120, 2, 2, 256, ssb_pkg::ANCHOR_GROUND);  // restart mid draw
    queue_steps(4);
    drain();

    // Random part: well-formed frames drawn at random scale, with noise words.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 66 : 0;
      recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 29 : 0;
      for (int d = 0; d < 4; d++) begin
        fw = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 127) : $urandom_range(1, 6);
        fh = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 127) : $urandom_range(1, 6);
        if (fw > 6 && fh > 6) fh = 2;
        queue_frame(fw, fh);
        queue_palette($urandom_range(0, 15), $urandom_range(0, 65535));
        queue_draw($urandom_range(0, 4095) - 2048 + (($urandom_range(0, 3) != 0) ? 2048 - 1800
                   : 0) * 0, $urandom_range(0, 260) - 10, fw, fh,
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                   : $urandom_range(16, 700), $urandom_range(0, 3));
        queue_steps($urandom_range(5, 90));
        if ($urandom_range(0, 3) == 0)
          queue_draw($urandom_range(0, 330) - 5, $urandom_range(0, 250) - 5, fw, fh,
                     $urandom_range(64, 512), $urandom_range(0, 2));
        queue_steps($urandom_range(0, 40));
        if (phase == 2 && d == 1) hold_request = 1'b1;
        drain();
      end
    end

    if (error_count == 0)
      $display("tb_scaled_sprite_blit_core: done, clean");
    else
      $display("tb_scaled_sprite_blit_core: done, errors");
    $finish;
  end

endmodule

[files.f]
rtl/ssb_pkg.sv
rtl/ssb_if.sv
rtl/ssb_ctrl.sv
rtl/ssb_dpath.sv
rtl/scaled_sprite_blit_core.sv
tb/tb_scaled_sprite_blit_core.sv
